@@ hdl/mbeg_pkg.sv @@
// Shared types, constants and helpers of the multi-button event generator.
`timescale 1ns / 1ps
package mbeg_pkg;

	localparam int NUM_BUTTONS_DEF = 4;
	localparam int LEVELS_W        = 4;
	localparam int INDEX_W         = 2;
	localparam int TMR_W           = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int LANE_SLOTS      = 3;
	localparam int SVC_SLOTS       = 3;

	typedef logic [TMR_W-1:0] tmr_t;
	localparam tmr_t TMR_MAX = '1;

	typedef enum logic [2:0] {
		EV_CLICK   = 3'd0,
		EV_PAIR    = 3'd1,
		EV_HOLD    = 3'd2,
		EV_REPEAT  = 3'd3,
		EV_RELEASE = 3'd4,
		EV_UPDATE  = 3'd5,
		EV_FACTORY = 3'd6,
		EV_SLEEP   = 3'd7
	} event_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAIRED          = 3'd0,
		REG_HOLD_MS         = 3'd1,
		REG_REPEAT_INTERVAL = 3'd2,
		REG_TAP_WINDOW      = 3'd3,
		REG_FACTORY_HOLD    = 3'd4,
		REG_SLEEP_IDLE      = 3'd5
	} reg_index_t;

	localparam tmr_t HOLD_MS_RST      = 16'd500;
	localparam tmr_t REPEAT_RST       = 16'd500;
	localparam tmr_t TAP_WINDOW_RST   = 16'd500;
	localparam tmr_t FACTORY_HOLD_RST = 16'd5000;
	localparam tmr_t SLEEP_IDLE_RST   = 16'd2000;
	localparam logic [1:0] DOUBLE_TAP = 2'd2;

	typedef struct packed {
		logic paired;
		tmr_t hold_ms;
		tmr_t repeat_interval;
		tmr_t tap_window;
		tmr_t factory_hold;
		tmr_t sleep_idle;
	} cfg_t;

	typedef struct packed {
		logic [LEVELS_W-1:0] button_levels;
		logic                service_level;
		logic                update_mode;
	} tick_t;

	typedef struct packed {
		logic [2:0]         event_code;
		logic [INDEX_W-1:0] btn_idx;
		logic               last_event;
	} event_t;

	// Per-button findings: hold start, hold repeat, then release, click or pair.
	typedef struct packed {
		logic [LANE_SLOTS-1:0] ev_valid;
		logic [2:0]            end_code;
		logic                  activity;
		logic                  pressed;
	} lane_res_t;

	typedef struct packed {
		logic update_ev;
		logic factory_ev;
		logic sleep_ev;
	} svc_res_t;

	function automatic tmr_t inc_sat(tmr_t t);
		return (t == TMR_MAX) ? t : t + tmr_t'(1);
	endfunction

endpackage

@@ hdl/mbeg_tick_if.sv @@
// Input channel carrying one millisecond tick request.
`timescale 1ns / 1ps
interface mbeg_tick_if;
	logic            valid;
	logic            ready;
	mbeg_pkg::tick_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/mbeg_event_if.sv @@
// Output channel carrying one event request.
`timescale 1ns / 1ps
interface mbeg_event_if;
	logic             valid;
	logic             ready;
	mbeg_pkg::event_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/mbeg_lane.sv @@
// One button lane: edge detection, hold and repeat timing for a single button.
`timescale 1ns / 1ps
module mbeg_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                level,
	input  mbeg_pkg::cfg_t      cfg,
	output mbeg_pkg::lane_res_t res
);
	import mbeg_pkg::*;

	logic was_q, seen_q, hold_q;
	tmr_t press_tmr_q, rep_tmr_q;

	logic rise, fall, seen1, hold1, hold_fire, rep_fire, rel;
	tmr_t press_tmr, rep_tmr1, rep_tmr2;

	always_comb begin
		rise      = level & ~was_q;
		fall      = ~level & was_q;
		seen1     = seen_q | rise;
		press_tmr = rise ? '0 : inc_sat(press_tmr_q);
		hold_fire = level & seen1 & ~hold_q & (press_tmr >= cfg.hold_ms);
		hold1     = hold_q | hold_fire;
		rep_tmr1  = hold_fire ? '0 : inc_sat(rep_tmr_q);
		rep_fire  = hold1 & (rep_tmr1 >= cfg.repeat_interval);
		rep_tmr2  = rep_fire ? '0 : rep_tmr1;
		rel       = fall & hold1;

		res.ev_valid[0] = hold_fire & cfg.paired;
		res.ev_valid[1] = rep_fire & cfg.paired;
		res.ev_valid[2] = (rel & cfg.paired) | (fall & ~hold1 & seen1);
		res.end_code    = rel ? EV_RELEASE : (cfg.paired ? EV_CLICK : EV_PAIR);
		res.activity    = rise | rep_fire | fall;
		res.pressed     = level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_q       <= 1'b0;
			seen_q      <= 1'b0;
			hold_q      <= 1'b0;
			press_tmr_q <= '0;
			rep_tmr_q   <= '0;
		end else if (accept) begin
			was_q       <= level;
			seen_q      <= seen1 & ~fall;
			hold_q      <= hold1 & ~fall;
			press_tmr_q <= press_tmr;
			rep_tmr_q   <= rep_tmr2;
		end
	end
endmodule

@@ hdl/mbeg_service.sv @@
// Service pin, factory hold and idle sleep tracking shared by all lanes.
`timescale 1ns / 1ps
module mbeg_service (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               svc,
	input  logic               upd,
	input  logic               lane_activity,
	input  logic               any_pressed,
	input  mbeg_pkg::cfg_t     cfg,
	output mbeg_pkg::svc_res_t res
);
	import mbeg_pkg::*;

	logic       svc_prev_q, sleep_sent_q;
	logic [1:0] tap_cnt_q;
	tmr_t       since_tap_q, hold_tmr_q, idle_q;

	logic       rise, fall, upd_ev, holding, act, sleep_ev;
	logic [1:0] tap_cnt1, tap_cnt2;
	tmr_t       since_tap, hold_tmr, idle;

	always_comb begin
		rise      = svc & ~svc_prev_q;
		fall      = ~svc & svc_prev_q;
		since_tap = inc_sat(since_tap_q);
		tap_cnt1  = tap_cnt_q;
		if (rise) begin
			if (since_tap < cfg.tap_window) begin
				tap_cnt1 = (tap_cnt_q == 2'b11) ? tap_cnt_q : tap_cnt_q + 2'd1;
			end else begin
				tap_cnt1 = 2'd1;
			end
			since_tap = '0;
		end
		upd_ev   = fall & (tap_cnt1 >= DOUBLE_TAP) & ~upd;
		tap_cnt2 = upd_ev ? 2'd0 : tap_cnt1;

		holding  = svc & ~upd;
		hold_tmr = holding ? inc_sat(hold_tmr_q) : '0;
		// An all-ones threshold disables the factory request.
		res.factory_ev = holding & (cfg.factory_hold != TMR_MAX)
			& (hold_tmr == cfg.factory_hold + tmr_t'(1));

		act      = lane_activity | upd_ev | holding;
		idle     = act ? '0 : inc_sat(idle_q);
		sleep_ev = ~upd & (idle > cfg.sleep_idle) & ~any_pressed & ~svc
			& (act ? 1'b1 : ~sleep_sent_q);

		res.update_ev = upd_ev;
		res.sleep_ev  = sleep_ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			svc_prev_q   <= 1'b0;
			sleep_sent_q <= 1'b0;
			tap_cnt_q    <= 2'd0;
			since_tap_q  <= TMR_MAX;
			hold_tmr_q   <= '0;
			idle_q       <= '0;
		end else if (accept) begin
			svc_prev_q   <= svc;
			sleep_sent_q <= sleep_ev | (~act & sleep_sent_q);
			tap_cnt_q    <= tap_cnt2;
			since_tap_q  <= since_tap;
			hold_tmr_q   <= hold_tmr;
			idle_q       <= idle;
		end
	end
endmodule

@@ hdl/mbeg_merge.sv @@
// Merging stage: holds the events of one tick and sends them out in slot order.
`timescale 1ns / 1ps
module mbeg_merge #(
	parameter int NSLOT = 15
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    load,
	input  logic [NSLOT-1:0]                        slot_valid,
	input  logic [NSLOT-1:0][2:0]                   slot_code,
	input  logic [NSLOT-1:0][mbeg_pkg::INDEX_W-1:0] slot_index,
	output logic                                    take_ok,
	mbeg_event_if.source                            events
);
	import mbeg_pkg::*;

	localparam int SEL_W = $clog2(NSLOT);

	logic [NSLOT-1:0]              pend_q;
	logic [NSLOT-1:0][2:0]         code_q;
	logic [NSLOT-1:0][INDEX_W-1:0] idx_q;
	logic                          out_valid_q;
	event_t                        out_q;

	logic             pop, last;
	logic [SEL_W-1:0] sel;
	logic [NSLOT-1:0] rest;

	always_comb begin
		sel = '0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel = SEL_W'(i);
			end
		end
		rest    = pend_q & ~(NSLOT'(1) << sel);
		last    = (rest == '0);
		pop     = (pend_q != '0) & (~out_valid_q | events.ready);
		// A new tick may enter once its predecessor's last event moves to the output.
		take_ok = (pend_q == '0) | (pop & last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pend_q <= slot_valid;
			end else if (pop) begin
				pend_q <= rest;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (events.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= slot_code;
			idx_q  <= slot_index;
		end
		if (pop) begin
			out_q.event_code <= code_q[sel];
			out_q.btn_idx    <= idx_q[sel];
			out_q.last_event <= last;
		end
	end

	assign events.valid   = out_valid_q;
	assign events.payload = out_q;
endmodule

@@ hdl/multi_button_event_generator.sv @@
// Top level of the multi-button event generator: config, lanes, service tracker, merge.
`timescale 1ns / 1ps
//  channel   dir  handshake            payload
//  tick      in   valid/ready          button_levels, service_level, update_mode
//  events    out  valid/ready          event_code, btn_idx, last_event
//  cfg       in   cfg_we (no wait)     cfg_index, cfg_data
//
//  A tick is evaluated in the cycle it is accepted; its events leave one per cycle from
//  the output register while the output is not stalled (up to 3*NUM_BUTTONS+3 slots, at
//  most 2*NUM_BUTTONS+1 set). The merge buffer sets the rate: the next tick is taken in
//  the cycle the last event of the previous one enters the output register, and ticks
//  without events go back to back. Reset clears the control state and loads the
//  register defaults; a stalled output holds its event, and the tick port stays not
//  ready while events of the previous tick are still queued behind it.
module multi_button_event_generator #(
	parameter int NUM_BUTTONS = mbeg_pkg::NUM_BUTTONS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	mbeg_tick_if.sink                        tick,
	mbeg_event_if.source                     events,
	input  logic                             cfg_we,
	input  logic [mbeg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mbeg_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mbeg_pkg::*;

	localparam int NSLOT = LANE_SLOTS * NUM_BUTTONS + SVC_SLOTS;
	localparam int SVC_BASE = LANE_SLOTS * NUM_BUTTONS;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.paired          <= 1'b0;
			cfg_q.hold_ms         <= HOLD_MS_RST;
			cfg_q.repeat_interval <= REPEAT_RST;
			cfg_q.tap_window      <= TAP_WINDOW_RST;
			cfg_q.factory_hold    <= FACTORY_HOLD_RST;
			cfg_q.sleep_idle      <= SLEEP_IDLE_RST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_PAIRED:          cfg_q.paired          <= cfg_data[0];
				REG_HOLD_MS:         cfg_q.hold_ms         <= cfg_data;
				REG_REPEAT_INTERVAL: cfg_q.repeat_interval <= cfg_data;
				REG_TAP_WINDOW:      cfg_q.tap_window      <= cfg_data;
				REG_FACTORY_HOLD:    cfg_q.factory_hold    <= cfg_data;
				REG_SLEEP_IDLE:      cfg_q.sleep_idle      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	logic accept, take_ok;
	assign tick.ready = take_ok;
	assign accept     = tick.valid & take_ok;

	lane_res_t [NUM_BUTTONS-1:0] lane_res;
	svc_res_t                    svc_res;
	logic [NUM_BUTTONS-1:0]      lane_act, lane_pressed, lane_hold_ev;

	logic [NSLOT-1:0]              slot_valid;
	logic [NSLOT-1:0][2:0]         slot_code;
	logic [NSLOT-1:0][INDEX_W-1:0] slot_index;

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		localparam logic [INDEX_W-1:0] LANE_IDX = INDEX_W'(i);
		logic level;

		// Buttons beyond the input field are never pressed.
		if (i < LEVELS_W) begin : g_wired
			assign level = tick.payload.button_levels[i];
		end else begin : g_unwired
			assign level = 1'b0;
		end

		mbeg_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.accept (accept),
			.level  (level),
			.cfg    (cfg_q),
			.res    (lane_res[i])
		);

		assign lane_act[i]     = lane_res[i].activity;
		assign lane_pressed[i] = lane_res[i].pressed;
		assign lane_hold_ev[i] = lane_res[i].ev_valid[0] | lane_res[i].ev_valid[1];

		assign slot_valid[LANE_SLOTS*i +: LANE_SLOTS] = lane_res[i].ev_valid;
		assign slot_code[LANE_SLOTS*i]                = EV_HOLD;
		assign slot_code[LANE_SLOTS*i+1]              = EV_REPEAT;
		assign slot_code[LANE_SLOTS*i+2]              = lane_res[i].end_code;
		assign slot_index[LANE_SLOTS*i]               = LANE_IDX;
		assign slot_index[LANE_SLOTS*i+1]             = LANE_IDX;
		assign slot_index[LANE_SLOTS*i+2]             = LANE_IDX;
	end

	mbeg_service u_service (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.svc           (tick.payload.service_level),
		.upd           (tick.payload.update_mode),
		.lane_activity (|lane_act),
		.any_pressed   (|lane_pressed),
		.cfg           (cfg_q),
		.res           (svc_res)
	);

	assign slot_valid[SVC_BASE]   = svc_res.update_ev;
	assign slot_valid[SVC_BASE+1] = svc_res.factory_ev;
	assign slot_valid[SVC_BASE+2] = svc_res.sleep_ev;
	assign slot_code[SVC_BASE]    = EV_UPDATE;
	assign slot_code[SVC_BASE+1]  = EV_FACTORY;
	assign slot_code[SVC_BASE+2]  = EV_SLEEP;
	assign slot_index[SVC_BASE]   = '0;
	assign slot_index[SVC_BASE+1] = '0;
	assign slot_index[SVC_BASE+2] = '0;

	mbeg_merge #(
		.NSLOT (NSLOT)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (accept),
		.slot_valid (slot_valid),
		.slot_code  (slot_code),
		.slot_index (slot_index),
		.take_ok    (take_ok),
		.events     (events)
	);

`ifndef ASSERT_OFF
	a_upd_blocks_service: assert property (@(posedge clk) disable iff (!arst_n)
		accept && tick.payload.update_mode |->
			!(svc_res.update_ev || svc_res.factory_ev || svc_res.sleep_ev))
		else $error("service event raised while update mode is active");

	a_unpaired_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_q.paired |-> lane_hold_ev == '0)
		else $error("hold event raised while unpaired");

	a_sleep_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && events.payload.event_code == EV_SLEEP |->
			events.payload.last_event && events.payload.btn_idx == '0)
		else $error("sleep event is not the final event of its tick");
`endif
endmodule
